/* design/mse_pkg.sv */
`timescale 1ns / 1ps
// mse_pkg: shared types and constants of the multi-stack engine.
// Used by mse_ctrl, mse_dp and multi_stack_engine_unit; depends on nothing.

package mse_pkg;

  localparam int OP_W        = 2;
  localparam int IDX_W       = 3;
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int STACKS_CFG_W = 4;
  localparam int DEPTH_CFG_W = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  // index space of the stack_index field
  localparam int IDX_SLOTS   = 2 ** IDX_W;

  // a display emits at most this many words, from the top down
  localparam int MAX_RESULTS = 16;
  localparam int REM_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [STACKS_CFG_W-1:0] STACKS_RESET = 4'd8;
  localparam logic [DEPTH_CFG_W-1:0]  DEPTH_RESET  = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_STACKS = 1'b0,
    CFG_ACTIVE_DEPTH  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         stack_index;
    logic signed [WORD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] data_out;
    logic                     last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch the input item
    logic eval;    // check, update counts, touch memory
    logic emit;    // load the output register
  } mse_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic last_pending;  // pending result is the last one of the item
  } mse_sts_t;

endpackage

/* design/multi_stack_engine_unit.sv */
`timescale 1ns / 1ps
// Multi-stack engine: a bank of LIFO stacks sharing one element memory.
// Channels: input item (in_valid/in_stall/in_item), results
// (out_valid/out_stall/out_item), config writes (cfg_valid/cfg_ready/
// cfg_index/cfg_data). An item transfers when valid is high and stall low.
// Each item gives one result with last set, except display, which gives one
// result per stored word (top first, up to 16) and sets last on the final one.
// The item is latched when it transfers and is evaluated in S_EVAL (checks,
// count update, memory access); its first result is then loaded into the output
// register in S_EMIT, which waits while the output register cannot take it. No
// new item is taken until the last result of the current one is loaded; a
// display loads its results one after another in S_EMIT, walking down the stack.
// The next item may transfer on the edge the last result is loaded.
// A stalled result holds the output register; the block then stops too.
// Reset clears all fill counts (every stack empty), active_stacks to 8 and
// active_depth to 16. Memory contents are not cleared and need no sweep.
// Depends on mse_pkg, mse_ctrl and mse_dp.

module multi_stack_engine_unit #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mse_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mse_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mse_pkg::CFG_DATA_W-1:0] cfg_data
);

  mse_pkg::mse_cmd_t cmd;
  mse_pkg::mse_sts_t sts;

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mse_dp #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* design/mse_ctrl.sv */
`timescale 1ns / 1ps
// mse_ctrl: sequencing state machine of the multi-stack engine.
// Depends on mse_pkg; drives mse_dp through mse_cmd_t, reads mse_sts_t.

module mse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mse_pkg::mse_sts_t sts,
  output mse_pkg::mse_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_pending) begin
            // next item may transfer on the same edge as the last result
            in_stall = 1'b0;
            if (in_valid) begin
              cmd.accept = 1'b1;
              state_next = S_EVAL;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_then_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.eval)
    else $error("accepted item not evaluated next cycle");

  a_eval_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |=> (state == S_EMIT))
    else $error("evaluation not followed by result phase");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output register occupied");

endmodule

/* design/mse_dp.sv */
`timescale 1ns / 1ps
// mse_dp: datapath of the multi-stack engine: config registers, fill counts,
// element memory and output register. Depends on mse_pkg; driven by mse_ctrl.

module mse_dp #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mse_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  mse_pkg::in_item_t                  in_item,
  input  mse_pkg::mse_cmd_t                  cmd,
  output mse_pkg::mse_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mse_pkg::out_item_t                 out_item
);

  // only stacks reachable by the index field get storage
  localparam int USED_STACKS = (NUM_STACKS < mse_pkg::IDX_SLOTS) ? NUM_STACKS
                                                                  : mse_pkg::IDX_SLOTS;
  localparam int MEM_WORDS = USED_STACKS * STACK_DEPTH;
  localparam int ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W    = (USED_STACKS > 1) ? $clog2(USED_STACKS) : 1;
  localparam int CMP_W     = (CNT_W > mse_pkg::DEPTH_CFG_W) ? CNT_W : mse_pkg::DEPTH_CFG_W;
  localparam int REM_W     = mse_pkg::REM_W;

  // configuration
  logic [mse_pkg::STACKS_CFG_W-1:0] active_stacks;
  logic [mse_pkg::DEPTH_CFG_W-1:0]  active_depth;

  // latched item
  mse_pkg::op_t                       op_r;
  logic [mse_pkg::IDX_W-1:0]          idx_r;
  logic signed [mse_pkg::WORD_W-1:0]  data_r;
  logic [ADDR_W-1:0]                  base_r;

  // per-stack fill counts
  logic [CNT_W-1:0] counts [USED_STACKS];

  // element memory
  logic [mse_pkg::WORD_W-1:0] mem [MEM_WORDS];
  logic [mse_pkg::WORD_W-1:0] rd_data;

  // pending result
  mse_pkg::status_t  pend_status;
  logic              use_mem;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  ptr;

  // evaluation
  logic [CNT_W-1:0]  cnt, cnt_m1, cnt_new, ptr_m1;
  logic              bad, full, empty;
  logic              ev_we, ev_re, ev_cnt_we, ev_mem;
  mse_pkg::status_t  ev_status;
  logic [REM_W-1:0]  ev_rem;
  logic              emit_re;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_stacks <= mse_pkg::STACKS_RESET;
      active_depth  <= mse_pkg::DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mse_pkg::CFG_ACTIVE_STACKS:
          active_stacks <= cfg_data[mse_pkg::STACKS_CFG_W-1:0];
        mse_pkg::CFG_ACTIVE_DEPTH:
          active_depth  <= cfg_data[mse_pkg::DEPTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_item.op;
      idx_r  <= in_item.stack_index;
      data_r <= in_item.data_in;
      base_r <= ADDR_W'(int'(in_item.stack_index) * STACK_DEPTH);
    end
  end

  assign cnt    = counts[idx_r[SIDX_W-1:0]];
  assign cnt_m1 = cnt - 1'b1;
  assign ptr_m1 = ptr - 1'b1;

  assign bad   = (mse_pkg::STACKS_CFG_W'(idx_r) >= active_stacks) ||
                 (int'(idx_r) >= NUM_STACKS);
  // effective depth is min(active_depth, STACK_DEPTH); cnt never passes STACK_DEPTH
  assign full  = (CMP_W'(cnt) >= CMP_W'(active_depth)) ||
                 (cnt == CNT_W'(STACK_DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    ev_we     = 1'b0;
    ev_re     = 1'b0;
    ev_cnt_we = 1'b0;
    ev_mem    = 1'b0;
    cnt_new   = cnt;
    ev_status = mse_pkg::ST_OK;
    ev_rem    = REM_W'(1);
    priority if (bad) begin
      ev_status = mse_pkg::ST_BAD_INDEX;
    end else if (op_r == mse_pkg::OP_PUSH) begin
      if (full) begin
        ev_status = mse_pkg::ST_FULL;
      end else begin
        ev_we     = 1'b1;
        ev_cnt_we = 1'b1;
        cnt_new   = cnt + 1'b1;
      end
    end else if (empty) begin
      ev_status = mse_pkg::ST_EMPTY;
    end else begin
      ev_re  = 1'b1;
      ev_mem = 1'b1;
      if (op_r == mse_pkg::OP_DISPLAY) begin
        ev_rem = (CMP_W'(cnt) >= CMP_W'(mse_pkg::MAX_RESULTS)) ?
                 REM_W'(mse_pkg::MAX_RESULTS) : REM_W'(cnt);
      end
      if (op_r == mse_pkg::OP_POP) begin
        ev_cnt_we = 1'b1;
        cnt_new   = cnt_m1;
      end
    end
  end

  assign sts.last_pending = (rem == REM_W'(1));
  assign sts.out_free     = !out_valid || !out_stall;

  // display walks down one word per emitted result
  assign emit_re = cmd.emit && !sts.last_pending;
  assign wr_addr = base_r + ADDR_W'(cnt);
  assign rd_addr = cmd.eval ? base_r + ADDR_W'(cnt_m1) : base_r + ADDR_W'(ptr_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USED_STACKS; i++) begin
        counts[i] <= '0;
      end
    end else if (cmd.eval && ev_cnt_we) begin
      counts[idx_r[SIDX_W-1:0]] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && ev_we) begin
      mem[wr_addr] <= data_r;
    end
    if ((cmd.eval && ev_re) || emit_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      pend_status <= ev_status;
      use_mem     <= ev_mem;
      rem         <= ev_rem;
      ptr         <= cnt_m1;
    end else if (emit_re) begin
      rem <= rem - 1'b1;
      ptr <= ptr_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.status   <= pend_status;
      out_item.data_out <= use_mem ? rd_data : '0;
      out_item.last     <= sts.last_pending;
    end
  end

  a_error_zero_data: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && pend_status != mse_pkg::ST_OK) |=> (out_item.data_out == '0))
    else $error("error result carries nonzero data");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    emit_re |-> (ptr != '0))
    else $error("display walked below the bottom of the stack");

  a_emit_has_result: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (rem != '0))
    else $error("result loaded with no result pending");

endmodule
